// ===== sv/php_pkg.sv =====
// shared types, constants and helpers for the packet header parser
package php_pkg;

  localparam int unsigned MAX_EXT_HEADERS_DEF = 6;
  localparam int unsigned LENGTH_BITS_DEF     = 16;

  // offsets carry one bit above the 16-bit length range
  localparam int unsigned OFF_W = 17;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_VLAN = 16'h8100;

  // address family codes
  localparam logic [1:0] FAM_IPV4 = 2'd1;
  localparam logic [1:0] FAM_IPV6 = 2'd2;

  localparam logic [7:0] NH_HOPOPT = 8'd0;
  localparam logic [7:0] NH_ICMP   = 8'd1;
  localparam logic [7:0] NH_TCP    = 8'd6;
  localparam logic [7:0] NH_UDP    = 8'd17;
  localparam logic [7:0] NH_ROUTE  = 8'd43;
  localparam logic [7:0] NH_FRAG   = 8'd44;
  localparam logic [7:0] NH_AUTH   = 8'd51;
  localparam logic [7:0] NH_ICMP6  = 8'd58;
  localparam logic [7:0] NH_DSTOPT = 8'd60;

  localparam logic [11:0] VID_MASK = 12'h0FFF;

  localparam logic [2:0]  LAST_REC = 3'd6;

  // one parsed packet, waiting for the record sequencer
  typedef struct packed {
    logic        status;
    logic [1:0]  fam;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [5:0]  dscp;
    logic        frag;
    logic [11:0] vlan;
    logic [15:0] l4_off;
    logic [15:0] pay_off;
    logic [127:0] src;
    logic [127:0] dst;
    logic [127:0] tw;
    logic [15:0] len;
    logic [15:0] l3_off;
    logic [15:0] port;
  } rec_t;

  // write one byte into a 128-bit big-endian pair of words
  function automatic logic [127:0] put_byte(logic [127:0] w, logic [3:0] idx,
                                            logic [7:0] b);
    logic [127:0] r;
    r = w;
    r[8 * (15 - int'(idx)) +: 8] = b;
    return r;
  endfunction

  // clamp an offset to 16 bits
  function automatic logic [15:0] sat16(logic [OFF_W-1:0] v);
    return v[OFF_W-1] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== sv/php_front.sv =====
// byte-wise header parser that builds one record set per packet
module php_front #(
  parameter int unsigned MAX_EXT_HEADERS = php_pkg::MAX_EXT_HEADERS_DEF,
  parameter int unsigned LENGTH_BITS     = php_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    byte_i,
  input  logic          eop_i,
  input  logic [15:0]   port_i,
  output logic          push_o,
  output php_pkg::rec_t rec_o
);

  localparam int unsigned OW  = php_pkg::OFF_W;
  localparam int unsigned ECW = $clog2(MAX_EXT_HEADERS + 2);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [ECW-1:0] EXT_MAX = ECW'(MAX_EXT_HEADERS);

  typedef enum logic [2:0] {
    PH_ETH, PH_VLAN, PH_IP4, PH_IP6, PH_EXT, PH_L4, PH_DONE
  } phase_e;

  phase_e ph_q, ph_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [OW-1:0]  hs_q, hs_d, req_q, req_d, l4_q, l4_d, pay_q, pay_d;
  logic [ECW-1:0] ext_q, ext_d;
  logic [15:0]    ets_q, ets_d, l3_q, l3_d;
  logic [127:0]   src_q, src_d, dst_q, dst_d, tw_q, tw_d;
  logic           err_q, err_d, fh_q, fh_d, frag_q, frag_d;
  logic [1:0]     fam_q, fam_d;
  logic [7:0]     proto_q, proto_d, ttl_q, ttl_d;
  logic [5:0]     dscp_q, dscp_d;
  logic [11:0]    vlan_q, vlan_d;
  logic [3:0]     ihl_q, ihl_d;

  logic [OW-1:0]  pos, rel, chain_off, l4_off, ext_len;
  logic [5:0]     r6;
  logic           in_win, do_chain, do_l4, opt, bad;
  php_pkg::rec_t  rec;

  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; hs_d = hs_q; req_d = req_q; l4_d = l4_q;
    pay_d = pay_q; ext_d = ext_q; ets_d = ets_q; l3_d = l3_q; src_d = src_q;
    dst_d = dst_q; tw_d = tw_q; err_d = err_q; fh_d = fh_q; frag_d = frag_q;
    fam_d = fam_q; proto_d = proto_q; ttl_d = ttl_q; dscp_d = dscp_q;
    vlan_d = vlan_q; ihl_d = ihl_q;
    pos = OW'(cnt_q);
    rel = pos - hs_q;
    in_win = (rel[OW-1:6] == '0);
    r6 = rel[5:0];
    do_chain = 1'b0; do_l4 = 1'b0;
    chain_off = '0; l4_off = '0; ext_len = '0; opt = 1'b0;
    rec = '0; bad = 1'b0;

    // consume one byte while below the length limit
    if (acc_i && cnt_q != LEN_MAX) begin
      cnt_d = cnt_q + 1'b1;
      if (ph_q != PH_DONE && pos >= hs_q && in_win) begin
        case (ph_q)
          PH_ETH: begin
            if (r6 == 6'd12 || r6 == 6'd13) ets_d = {ets_q[7:0], byte_i};
            if (r6 == 6'd13) begin
              if (ets_d == php_pkg::ETH_VLAN) begin
                ph_d = PH_VLAN; hs_d = OW'(14);
                if (req_d < OW'(18)) req_d = OW'(18);
              end else begin
                l3_d = 16'd14; hs_d = OW'(14);
                if (ets_d == php_pkg::ETH_IPV4) begin
                  fam_d = php_pkg::FAM_IPV4; ph_d = PH_IP4;
                  if (req_d < OW'(34)) req_d = OW'(34);
                end else if (ets_d == php_pkg::ETH_IPV6) begin
                  fam_d = php_pkg::FAM_IPV6; ph_d = PH_IP6;
                  if (req_d < OW'(54)) req_d = OW'(54);
                end else begin
                  err_d = 1'b1; ph_d = PH_DONE;
                end
              end
            end
          end
          PH_VLAN: begin
            if (r6 < 6'd4) ets_d = {ets_q[7:0], byte_i};
            if (r6 == 6'd1) vlan_d = ets_d[11:0] & php_pkg::VID_MASK;
            if (r6 == 6'd3) begin
              l3_d = 16'd18; hs_d = OW'(18);
              if (ets_d == php_pkg::ETH_IPV4) begin
                fam_d = php_pkg::FAM_IPV4; ph_d = PH_IP4;
                if (req_d < OW'(38)) req_d = OW'(38);
              end else if (ets_d == php_pkg::ETH_IPV6) begin
                fam_d = php_pkg::FAM_IPV6; ph_d = PH_IP6;
                if (req_d < OW'(58)) req_d = OW'(58);
              end else begin
                err_d = 1'b1; ph_d = PH_DONE;
              end
            end
          end
          PH_IP4: begin
            if (r6 == 6'd0) ihl_d = byte_i[3:0];
            else if (r6 == 6'd1) dscp_d = byte_i[7:2];
            else if (r6 == 6'd6 || r6 == 6'd7) begin
              ets_d = {ets_q[7:0], byte_i};
              if (r6 == 6'd7) frag_d = (ets_d[13:0] != '0);
            end else if (r6 == 6'd8) ttl_d = byte_i;
            else if (r6 == 6'd9) proto_d = byte_i;
            else if (r6 >= 6'd12 && r6 <= 6'd15)
              src_d = php_pkg::put_byte(src_q, r6[3:0], byte_i);
            else if (r6 >= 6'd16 && r6 <= 6'd19)
              dst_d = php_pkg::put_byte(dst_q, {2'b11, r6[1:0]}, byte_i);
            if (r6 == 6'd19) begin
              if (ihl_q < 4'd5) begin
                err_d = 1'b1; ph_d = PH_DONE;
              end else begin
                do_l4 = 1'b1; l4_off = hs_q + OW'({ihl_q, 2'b00});
              end
            end
          end
          PH_IP6: begin
            if (r6 < 6'd2) begin
              ets_d = {ets_q[7:0], byte_i};
              if (r6 == 6'd1) dscp_d = ets_d[11:6];
            end else if (r6 == 6'd6) proto_d = byte_i;
            else if (r6 == 6'd7) ttl_d = byte_i;
            else if (r6 >= 6'd8 && r6 <= 6'd23)
              src_d = php_pkg::put_byte(src_q, 4'(r6 - 6'd8), byte_i);
            else if (r6 >= 6'd24 && r6 <= 6'd39)
              dst_d = php_pkg::put_byte(dst_q, 4'(r6 - 6'd24), byte_i);
            if (r6 == 6'd39) begin
              do_chain = 1'b1; chain_off = hs_q + OW'(40);
            end
          end
          PH_EXT: begin
            if (r6 == 6'd0) begin
              proto_d = byte_i;
              if (fh_q) begin
                frag_d = 1'b1; do_chain = 1'b1; chain_off = hs_q + OW'(8);
              end
            end else if (r6 == 6'd1) begin
              ext_len = (OW'(byte_i) + OW'(1)) << 3;
              chain_off = hs_q + ext_len;
              if (req_d < chain_off) req_d = chain_off;
              do_chain = 1'b1;
            end
          end
          PH_L4: begin
            if (proto_q == php_pkg::NH_TCP) begin
              if (r6 < 6'd4) tw_d = php_pkg::put_byte(tw_q, r6[3:0], byte_i);
              else if (r6 < 6'd12)
                tw_d = php_pkg::put_byte(tw_q, 4'(r6 + 6'd4), byte_i);
              else if (r6 == 6'd12) pay_d = hs_q + OW'({byte_i[7:4], 2'b00});
              else if (r6 == 6'd13) tw_d = php_pkg::put_byte(tw_q, 4'd4, byte_i);
            end else if (proto_q == php_pkg::NH_UDP) begin
              if (r6 < 6'd4) tw_d = php_pkg::put_byte(tw_q, r6[3:0], byte_i);
            end else if (proto_q == php_pkg::NH_ICMP ||
                         proto_q == php_pkg::NH_ICMP6) begin
              if (r6 == 6'd0) tw_d = php_pkg::put_byte(tw_q, 4'd5, byte_i);
              else if (r6 == 6'd1) tw_d = php_pkg::put_byte(tw_q, 4'd6, byte_i);
              else if (r6 == 6'd4 || r6 == 6'd5)
                tw_d = php_pkg::put_byte(tw_q, {3'b000, r6[0]}, byte_i);
            end
          end
          default: ;
        endcase

        // follow the ipv6 extension header chain
        if (do_chain) begin
          opt = (proto_d == php_pkg::NH_HOPOPT || proto_d == php_pkg::NH_ROUTE ||
                 proto_d == php_pkg::NH_AUTH || proto_d == php_pkg::NH_DSTOPT);
          if (ext_q < EXT_MAX && (opt || proto_d == php_pkg::NH_FRAG)) begin
            ext_d = ext_q + 1'b1;
            fh_d = (proto_d == php_pkg::NH_FRAG);
            hs_d = chain_off;
            ph_d = PH_EXT;
            if (req_d < chain_off + (fh_d ? OW'(8) : OW'(2)))
              req_d = chain_off + (fh_d ? OW'(8) : OW'(2));
          end else begin
            do_l4 = 1'b1; l4_off = chain_off;
          end
        end

        // enter the transport header
        if (do_l4) begin
          l4_d = l4_off; hs_d = l4_off; ph_d = PH_L4; pay_d = l4_off;
          if (proto_d == php_pkg::NH_TCP) begin
            if (req_d < l4_off + OW'(20)) req_d = l4_off + OW'(20);
          end else if (proto_d == php_pkg::NH_UDP || proto_d == php_pkg::NH_ICMP ||
                       proto_d == php_pkg::NH_ICMP6) begin
            if (req_d < l4_off + OW'(8)) req_d = l4_off + OW'(8);
            pay_d = l4_off + OW'(8);
          end
        end
      end
    end

    // build the record set on the final byte
    bad = err_d || (OW'(cnt_d) < req_d);
    rec.len = 16'(cnt_d);
    rec.l3_off = l3_d;
    rec.port = port_i;
    rec.status = bad;
    if (!bad) begin
      rec.fam = fam_d; rec.proto = proto_d; rec.ttl = ttl_d; rec.dscp = dscp_d;
      rec.frag = frag_d; rec.vlan = vlan_d;
      rec.l4_off = php_pkg::sat16(l4_d); rec.pay_off = php_pkg::sat16(pay_d);
      rec.src = src_d; rec.dst = dst_d; rec.tw = tw_d;
    end

    // clear per-packet state after the final byte
    if (acc_i && eop_i) begin
      ph_d = PH_ETH; cnt_d = '0; hs_d = '0; req_d = OW'(14); l4_d = '0; pay_d = '0;
      ext_d = '0; ets_d = '0; l3_d = '0; src_d = '0; dst_d = '0; tw_d = '0;
      err_d = 1'b0; fh_d = 1'b0; frag_d = 1'b0; fam_d = '0; proto_d = '0;
      ttl_d = '0; dscp_d = '0; vlan_d = '0; ihl_d = '0;
    end
  end

  assign push_o = acc_i && eop_i;
  assign rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_ETH; cnt_q <= '0; hs_q <= '0; req_q <= OW'(14); l4_q <= '0;
      pay_q <= '0; ext_q <= '0; ets_q <= '0; l3_q <= '0; src_q <= '0;
      dst_q <= '0; tw_q <= '0; err_q <= 1'b0; fh_q <= 1'b0; frag_q <= 1'b0;
      fam_q <= '0; proto_q <= '0; ttl_q <= '0; dscp_q <= '0; vlan_q <= '0;
      ihl_q <= '0;
    end else begin
      ph_q <= ph_d; cnt_q <= cnt_d; hs_q <= hs_d; req_q <= req_d; l4_q <= l4_d;
      pay_q <= pay_d; ext_q <= ext_d; ets_q <= ets_d; l3_q <= l3_d; src_q <= src_d;
      dst_q <= dst_d; tw_q <= tw_d; err_q <= err_d; fh_q <= fh_d; frag_q <= frag_d;
      fam_q <= fam_d; proto_q <= proto_d; ttl_q <= ttl_d; dscp_q <= dscp_d;
      vlan_q <= vlan_d; ihl_q <= ihl_d;
    end
  end

endmodule

// ===== sv/php_queue.sv =====
// two-entry queue of parsed packets between parser and sequencer
module php_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  php_pkg::rec_t rec_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output php_pkg::rec_t head_o
);

  php_pkg::rec_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== sv/php_back.sv =====
// sequencer that emits seven record words per parsed packet
module php_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  php_pkg::rec_t head_i,
  output logic          pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o,
  output logic          m_axis_tlast_o
);

  logic [2:0]   idx_q;
  logic         vld_q;
  logic [136:0] dat_q;
  logic         last_q;
  logic         load;
  logic [63:0]  word;

  assign load  = !empty_i && (!vld_q || m_axis_tready_i);
  assign pop_o = load && (idx_q == php_pkg::LAST_REC);

  // select the record word for the current index
  always_comb begin
    case (idx_q)
      3'd0:    word = head_i.src[127:64];
      3'd1:    word = head_i.src[63:0];
      3'd2:    word = head_i.dst[127:64];
      3'd3:    word = head_i.dst[63:0];
      3'd4:    word = head_i.tw[127:64];
      3'd5:    word = head_i.tw[63:0];
      3'd6:    word = {head_i.len, head_i.l3_off, head_i.port, 16'h0000};
      default: word = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; vld_q <= 1'b0; last_q <= 1'b0; dat_q <= '0;
    end else begin
      if (load) begin
        vld_q  <= 1'b1;
        last_q <= (idx_q == php_pkg::LAST_REC);
        dat_q  <= {word, idx_q, head_i.pay_off, head_i.l4_off, head_i.vlan,
                   head_i.frag, head_i.dscp, head_i.ttl, head_i.proto,
                   head_i.fam, head_i.status};
        idx_q  <= (idx_q == php_pkg::LAST_REC) ? 3'd0 : idx_q + 3'd1;
      end else if (m_axis_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {7'd0, dat_q};
  assign m_axis_tlast_o  = last_q;

endmodule

// ===== sv/packet_header_parser.sv =====
// top level of the packet header parser
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      one packet byte, tlast on the final byte
//  m_axis   out  m_axis_tvalid/tready      one record word, tlast on the seventh
//
// one byte per cycle is parsed; the final byte of a packet queues one record set
// which the sequencer sends as seven words, one per cycle while m_axis_tready is
// high. the input stalls only while the two-entry packet queue is full. reset is
// asynchronous and active low and starts the parser at the ethernet header with
// empty queue and output.
module packet_header_parser #(
  parameter int unsigned MAX_EXT_HEADERS = php_pkg::MAX_EXT_HEADERS_DEF,
  parameter int unsigned LENGTH_BITS     = php_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [23:0]  s_axis_tdata_i,   // data_byte[7:0], ingress_port[23:8]
  input  logic         s_axis_tlast_i,   // end_of_packet
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[0], family[2:1], protocol[10:3], hop_limit[18:11], dscp[24:19],
  // frag_flag[25], vlan_id[37:26], l4_start[53:38], data_start[69:54],
  // record_index[72:70], record_word[136:73], zero fill above
  output logic [143:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o    // last_record
);

  logic          acc, push, full, empty, pop;
  php_pkg::rec_t rec, head;

  assign s_axis_tready_o = !full;
  assign acc = s_axis_tvalid_i && !full;

  php_front #(
    .MAX_EXT_HEADERS (MAX_EXT_HEADERS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (s_axis_tdata_i[7:0]),
    .eop_i  (s_axis_tlast_i),
    .port_i (s_axis_tdata_i[23:8]),
    .push_o (push),
    .rec_o  (rec)
  );

  php_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  php_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
